/* hw/rtl/hri_pkg.sv */
// Shared types, constants and helpers for the hall rotor angle interpolator.
// Used by hri_cfg, hall_rotor_angle_interpolator and the testbench.
`default_nettype none

package hri_pkg;

    // Default tick counter width
    localparam int COUNTER_BITS_DEF = 16;

    // APB register file geometry
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;

    // Register indexes (byte address = 4 * index)
    localparam logic [2:0] REG_POS_CORR    = 3'd0;
    localparam logic [2:0] REG_PHASE_DELTA = 3'd1;
    localparam logic [2:0] REG_INTERP_THR  = 3'd2;
    localparam logic [2:0] REG_CNT_LIMIT   = 3'd3;
    localparam logic [2:0] REG_TPS         = 3'd4;

    // Register reset values
    localparam logic [7:0]  POS_CORR_RST    = 8'd0;
    localparam logic [7:0]  PHASE_DELTA_RST = 8'd0;
    localparam logic [15:0] INTERP_THR_RST  = 16'd1000;
    localparam logic [15:0] CNT_LIMIT_RST   = 16'd8000;
    localparam logic [15:0] TPS_RST         = 16'd15625;

    // Motor modes
    localparam logic [1:0] MODE_COAST = 2'd0;
    localparam logic [1:0] MODE_SLOW  = 2'd1;
    localparam logic [1:0] MODE_RUN   = 2'd2;

    // Hall codes with special meaning
    localparam logic [2:0] HALL_ALL_LOW  = 3'd0;
    localparam logic [2:0] HALL_ALL_HIGH = 3'd7;
    localparam logic [2:0] HALL_REF      = 3'd3;

    // Speed value reported when the period is zero
    localparam logic [15:0] ERPS_MAX = 16'hffff;
    // Period value forced on coast
    localparam logic [15:0] PERIOD_MAX = 16'hffff;

    // Stream payload widths
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 48;

    // Configuration register set
    typedef struct packed {
        logic [7:0]  pos_corr;
        logic [7:0]  phase_delta;
        logic [15:0] interp_thr;
        logic [15:0] cnt_limit;
        logic [15:0] tps;
    } hri_cfg_t;

    // Base angle of each hall sector, 1/256 turn
    function automatic logic [7:0] sector_base(input logic [2:0] code);
        logic [7:0] ang;
        case (code)
            3'd4:    ang = 8'd1;
            3'd6:    ang = 8'd43;
            3'd2:    ang = 8'd85;
            3'd3:    ang = 8'd128;
            3'd1:    ang = 8'd171;
            3'd5:    ang = 8'd213;
            default: ang = 8'd0;
        endcase
        return ang;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/hri_cfg.sv */
// APB configuration register file for the hall rotor angle interpolator.
// Depends on hri_pkg for register indexes, reset values and hri_cfg_t.
`default_nettype none

module hri_cfg (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [hri_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [hri_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [hri_pkg::APB_DATA_W-1:0] prdata,
    output logic                                pready,
    output hri_pkg::hri_cfg_t                   cfg
);
    import hri_pkg::*;

    hri_cfg_t   cfg_reg;
    logic [2:0] reg_idx;
    logic       wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign wr_en   = psel & penable & pwrite;
    assign cfg     = cfg_reg;

    // Register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.pos_corr    <= POS_CORR_RST;
            cfg_reg.phase_delta <= PHASE_DELTA_RST;
            cfg_reg.interp_thr  <= INTERP_THR_RST;
            cfg_reg.cnt_limit   <= CNT_LIMIT_RST;
            cfg_reg.tps         <= TPS_RST;
        end else if (wr_en) begin
            case (reg_idx)
                REG_POS_CORR:    cfg_reg.pos_corr    <= pwdata[7:0];
                REG_PHASE_DELTA: cfg_reg.phase_delta <= pwdata[7:0];
                REG_INTERP_THR:  cfg_reg.interp_thr  <= pwdata[15:0];
                REG_CNT_LIMIT:   cfg_reg.cnt_limit   <= pwdata[15:0];
                REG_TPS:         cfg_reg.tps         <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // Read mux
    always_comb begin
        case (reg_idx)
            REG_POS_CORR:    prdata = APB_DATA_W'(cfg_reg.pos_corr);
            REG_PHASE_DELTA: prdata = APB_DATA_W'(cfg_reg.phase_delta);
            REG_INTERP_THR:  prdata = APB_DATA_W'(cfg_reg.interp_thr);
            REG_CNT_LIMIT:   prdata = APB_DATA_W'(cfg_reg.cnt_limit);
            REG_TPS:         prdata = APB_DATA_W'(cfg_reg.tps);
            default:         prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

/* hw/rtl/hri_divider.sv */
// Shared restoring divider, one quotient bit per cycle.
// Standalone; instantiated by hall_rotor_angle_interpolator.
`default_nettype none

module hri_divider #(
    parameter int NUM_W = 24,
    parameter int DEN_W = 16
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             start,
    input  wire logic [NUM_W-1:0] num,
    input  wire logic [DEN_W-1:0] den,
    output logic                  done,
    output logic      [NUM_W-1:0] quot
);
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic [NUM_W-1:0] quot_reg;

    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             fits;
    logic [DEN_W-1:0] rem_next;
    logic [NUM_W-1:0] quot_next;

    // One shift-compare-subtract step
    always_comb begin
        trial     = {rem_reg, quot_reg[NUM_W-1]};
        diff      = trial - {1'b0, den_reg};
        fits      = (trial >= {1'b0, den_reg});
        rem_next  = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        quot_next = {quot_reg[NUM_W-2:0], fits};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(NUM_W);
                rem_reg  <= '0;
                quot_reg <= num;
                den_reg  <= den;
            end else if (busy_reg) begin
                rem_reg  <= rem_next;
                quot_reg <= quot_next;
                cnt_reg  <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

`default_nettype wire

/* hw/rtl/hall_rotor_angle_interpolator.sv */
// Hall sensor rotor angle interpolator, top level: step sequencer and state.
// Depends on hri_pkg, hri_cfg (APB registers) and hri_divider (shared divider).
//
// Usage: one s_ transaction per PWM tick carries the hall code, a current
// sample and the ADC-busy flag. Every accepted transaction yields exactly one
// m_ transaction with rotor angle, speed in erps, filtered current, motor mode
// and interpolated sector angle.
// Sequence: the hall, counter and coast logic settle in the accept cycle; then
// one shared restoring divider runs up to two divisions, speed on a reference
// edge and the in-sector angle while running, and the result then moves into
// the output register.
// s_tready is high only while no item is in work. A finished result sits in
// the output register, so the next item may be accepted while the receiver
// stalls; a further result waits until that register is taken.
// Reset (aresetn low, synchronous) clears all state to mode running very slow,
// loads register defaults and drops m_tvalid.
// Configuration: APB registers at byte addresses 0,4,8,12,16; write only
// while no item is in work.
`default_nettype none

module hall_rotor_angle_interpolator #(
    parameter int COUNTER_BITS = hri_pkg::COUNTER_BITS_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // tdata: hall_code[2:0], current_sample[12:3], adc_busy[13], zero pad
    input  wire logic [hri_pkg::S_TDATA_W-1:0]  s_tdata,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // tdata: rotor_angle[7:0], speed_erps[23:8], current_avg[33:24],
    //        motor_mode[35:34], interp_angle[43:36], zero pad
    output logic      [hri_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [hri_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [hri_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [hri_pkg::APB_DATA_W-1:0] prdata,
    output logic                                pready
);
    import hri_pkg::*;

    localparam int CB    = COUNTER_BITS;
    localparam int NUM_W = CB + 8;
    localparam int DEN_W = (CB > 16) ? CB : 16;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ERPS_GO,
        ST_ERPS_WAIT,
        ST_INTERP_GO,
        ST_INTERP_WAIT,
        ST_LOAD
    } state_t;

    typedef struct packed {
        logic [CB-1:0] tick;
        logic [15:0]   period;
        logic [15:0]   speed;
        logic [1:0]    mode;
        logic [2:0]    last_hall;
        logic [7:0]    abs_angle;
        logic [7:0]    angle;
        logic [7:0]    interp;
        logic [11:0]   accum;
        logic [9:0]    filt;
        logic [15:0]   erps;
        logic [CB-1:0] erps_den;
        logic          need_erps;
        logic          need_interp;
    } hri_state_t;

    // State after reset: everything zero, mode running very slow
    localparam hri_state_t STATE_RST = '{mode: MODE_SLOW, default: '0};

    hri_cfg_t   cfg;
    state_t     state_reg;
    hri_state_t st_reg;
    hri_state_t st_next;
    logic       m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic       out_load;

    logic [2:0] in_code;
    logic [9:0] in_sample;
    logic       in_busy;

    logic             div_start;
    logic [NUM_W-1:0] div_num;
    logic [DEN_W-1:0] div_den;
    logic             div_done;
    logic [NUM_W-1:0] div_quot;

    // Hall step: one sector transition or reference edge
    function automatic hri_state_t hall_step(input hri_state_t s, input logic [2:0] code,
                                             input logic [9:0] smp, input logic busy,
                                             input hri_cfg_t c);
        hri_state_t r;
        logic [11:0] acc;
        r   = s;
        acc = s.accum;
        if (!(code == s.last_hall && s.mode != MODE_COAST)) begin
            r.last_hall = code;
            if (code != HALL_ALL_LOW && code != HALL_ALL_HIGH) begin
                if (code == HALL_REF) begin
                    // current filter: acc - acc/4 + sample
                    if (!busy) begin
                        acc     = s.accum - {2'b00, s.accum[11:2]};
                        acc     = acc + {2'b00, smp};
                        r.accum = acc;
                        r.filt  = acc[11:2];
                    end
                    r.period = 16'(s.tick);
                    if (s.mode != MODE_COAST) begin
                        r.speed = 16'(s.tick);
                    end
                    r.mode = (r.speed > c.interp_thr) ? MODE_SLOW : MODE_RUN;
                    if (s.tick == '0) begin
                        r.erps      = ERPS_MAX;
                        r.need_erps = 1'b0;
                    end else begin
                        r.need_erps = 1'b1;
                        r.erps_den  = s.tick;
                    end
                    r.tick      = '0;
                    r.interp    = '0;
                    r.abs_angle = sector_base(code) + c.phase_delta;
                    r.angle     = r.abs_angle + c.pos_corr;
                end else if (s.mode != MODE_RUN) begin
                    r.abs_angle = sector_base(code) + c.phase_delta;
                    r.angle     = r.abs_angle + c.pos_corr;
                end
            end
        end
        return r;
    endfunction

    hri_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    hri_divider #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .quot    (div_quot)
    );

    assign in_code   = s_tdata[2:0];
    assign in_sample = s_tdata[12:3];
    assign in_busy   = s_tdata[13];

    // Tick update: hall step, counter, coast with repeated hall step, run check
    always_comb begin
        st_next             = st_reg;
        st_next.need_erps   = 1'b0;
        st_next.need_interp = 1'b0;
        st_next = hall_step(st_next, in_code, in_sample, in_busy, cfg);
        if (DEN_W'(st_next.tick) < DEN_W'(cfg.cnt_limit)) begin
            st_next.tick = st_next.tick + CB'(1);
        end else begin
            st_next.tick   = '0;
            st_next.period = PERIOD_MAX;
            st_next.speed  = PERIOD_MAX;
            st_next.interp = '0;
            st_next.mode   = MODE_COAST;
            st_next = hall_step(st_next, in_code, in_sample, in_busy, cfg);
        end
        if (st_next.mode == MODE_RUN) begin
            if (st_next.period == '0) begin
                st_next.interp = '0;
                st_next.angle  = st_next.abs_angle + cfg.pos_corr;
            end else begin
                st_next.need_interp = 1'b1;
            end
        end
    end

    // Divider operands
    always_comb begin
        div_start = (state_reg == ST_ERPS_GO) || (state_reg == ST_INTERP_GO);
        if (state_reg == ST_INTERP_GO) begin
            div_num = {st_reg.tick, 8'h00};
            div_den = DEN_W'(st_reg.period);
        end else begin
            div_num = NUM_W'(cfg.tps);
            div_den = DEN_W'(st_reg.erps_den);
        end
    end

    // Result moves into the output register once that register is free
    assign out_load = (state_reg == ST_LOAD) && (!m_tvalid_reg || m_tready);

    // Sequencer, state and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
            st_reg       <= STATE_RST;
        end else begin
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
                m_tdata_reg  <= {4'h0, st_reg.interp, st_reg.mode, st_reg.filt,
                                 st_reg.erps, st_reg.angle};
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        st_reg <= st_next;
                        if (st_next.need_erps) begin
                            state_reg <= ST_ERPS_GO;
                        end else if (st_next.need_interp) begin
                            state_reg <= ST_INTERP_GO;
                        end else begin
                            state_reg <= ST_LOAD;
                        end
                    end
                end
                ST_ERPS_GO: begin
                    state_reg <= ST_ERPS_WAIT;
                end
                ST_ERPS_WAIT: begin
                    if (div_done) begin
                        st_reg.erps <= div_quot[15:0];
                        state_reg   <= st_reg.need_interp ? ST_INTERP_GO : ST_LOAD;
                    end
                end
                ST_INTERP_GO: begin
                    state_reg <= ST_INTERP_WAIT;
                end
                ST_INTERP_WAIT: begin
                    if (div_done) begin
                        st_reg.interp <= div_quot[7:0];
                        st_reg.angle  <= st_reg.abs_angle + cfg.pos_corr + div_quot[7:0];
                        state_reg     <= ST_LOAD;
                    end
                end
                ST_LOAD: begin
                    if (out_load) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire

/* tb/tb_hall_rotor_angle_interpolator.sv */
// Self-checking testbench for the hall rotor angle interpolator.
// Needs hri_pkg and the hall_rotor_angle_interpolator RTL; drives the stream
// and APB ports, predicts every result in SystemVerilog and checks each one.
module tb_hall_rotor_angle_interpolator;
    timeunit 1ns;
    timeprecision 1ps;
    import hri_pkg::*;

    localparam int CLK_HALF      = 4;
    localparam int RESET_CYCLES  = 12;
    localparam int SETTLE_CYCLES = 64;    // one item with both divisions, plus margin
    localparam int QUIET_LIMIT   = 5000;  // cycles with no stream transaction
    localparam int PHASES        = 9;
    localparam int PHASE_TICKS   = 115;
    localparam int HOLD_CYCLES   = 600;

    // Hall codes in forward rotation order (sector angles 1, 43, 85, 128, 171, 213)
    localparam logic [2:0] HALL_SEC0 = 3'd4;
    localparam logic [2:0] HALL_SEC1 = 3'd6;
    localparam logic [2:0] HALL_SEC2 = 3'd2;
    localparam logic [2:0] HALL_SEC4 = 3'd1;
    localparam logic [2:0] HALL_SEC5 = 3'd5;
    localparam logic [17:0] ROT_ORDER =
        {HALL_SEC5, HALL_SEC4, HALL_REF, HALL_SEC2, HALL_SEC1, HALL_SEC0};

    // Base angle per hall code, code 0 in the low byte
    localparam logic [63:0] SECTOR_ANGLES =
        {8'd0, 8'd43, 8'd213, 8'd1, 8'd128, 8'd85, 8'd171, 8'd0};

    typedef struct {
        logic [7:0]  angle;
        logic [15:0] erps;
        logic [9:0]  current;
        logic [1:0]  mode;
        logic [7:0]  interp;
    } tick_result_t;

    // DUT ports
    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic [S_TDATA_W-1:0]  s_tdata  = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0] paddr    = '0;
    logic [APB_DATA_W-1:0] pwdata   = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // Register copies
    logic [7:0]  cfg_pos_corr    = POS_CORR_RST;
    logic [7:0]  cfg_phase_delta = PHASE_DELTA_RST;
    logic [15:0] cfg_interp_thr  = INTERP_THR_RST;
    logic [15:0] cfg_cnt_limit   = CNT_LIMIT_RST;
    logic [15:0] cfg_tps         = TPS_RST;

    // Predicted block state
    logic [15:0] mdl_ticks        = '0;
    logic [15:0] mdl_period       = '0;
    logic [15:0] mdl_speed_period = '0;
    logic [1:0]  mdl_mode         = MODE_SLOW;
    logic [2:0]  mdl_last_hall    = '0;
    logic [7:0]  mdl_abs_angle    = '0;
    logic [7:0]  mdl_angle        = '0;
    logic [7:0]  mdl_interp       = '0;
    logic [11:0] mdl_accum        = '0;
    logic [9:0]  mdl_current      = '0;
    logic [15:0] mdl_erps         = '0;

    tick_result_t pending_results[$];
    int fail_count    = 0;
    int ticks_sent    = 0;
    int reg_writes    = 0;
    int mode_hits[4]  = '{0, 0, 0, 0};
    int send_idle_pct = 12;
    int recv_idle_pct = 75;
    int hold_left     = 0;

    hall_rotor_angle_interpolator u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tdata (s_tdata),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .m_tdata (m_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #CLK_HALF aclk = 1'b1;
        #CLK_HALF aclk = 1'b0;
    end

    // ---------------- predictor ----------------

    function automatic void load_sector(input logic [2:0] code);
        mdl_abs_angle = SECTOR_ANGLES[code*8 +: 8] + cfg_phase_delta;
        mdl_angle     = mdl_abs_angle + cfg_pos_corr;
    endfunction

    // Hall step: runs on a code change, or every time while coasting
    function automatic void hall_edge(input logic [2:0] code, input logic [9:0] sample,
                                      input logic busy);
        if (code == mdl_last_hall && mdl_mode != MODE_COAST)
            return;
        mdl_last_hall = code;
        if (code == HALL_ALL_LOW || code == HALL_ALL_HIGH)
            return;
        if (code == HALL_REF) begin
            if (!busy) begin
                mdl_accum   = mdl_accum - (mdl_accum >> 2);
                mdl_accum   = mdl_accum + {2'b00, sample};
                mdl_current = mdl_accum[11:2];
            end
            mdl_period = mdl_ticks;
            if (mdl_mode != MODE_COAST)
                mdl_speed_period = mdl_ticks;
            mdl_mode = (mdl_speed_period > cfg_interp_thr) ? MODE_SLOW : MODE_RUN;
            mdl_erps = (mdl_ticks == 16'd0) ? ERPS_MAX : cfg_tps / mdl_ticks;
            mdl_ticks  = '0;
            mdl_interp = '0;
            load_sector(code);
        end else if (mdl_mode != MODE_RUN) begin
            load_sector(code);
        end
    endfunction

    // One PWM tick: hall step, tick counter with coast, then interpolation
    function automatic tick_result_t predict_tick(input logic [2:0] code,
                                                  input logic [9:0] sample,
                                                  input logic busy);
        logic [23:0]  quot;
        tick_result_t r;
        hall_edge(code, sample, busy);
        if (mdl_ticks < cfg_cnt_limit) begin
            mdl_ticks = mdl_ticks + 16'd1;
        end else begin
            mdl_ticks        = '0;
            mdl_period       = PERIOD_MAX;
            mdl_speed_period = PERIOD_MAX;
            mdl_interp       = '0;
            mdl_mode         = MODE_COAST;
            hall_edge(code, sample, busy);
        end
        if (mdl_mode == MODE_RUN) begin
            if (mdl_period == 16'd0) begin
                mdl_interp = '0;
            end else begin
                quot       = {mdl_ticks, 8'h00} / mdl_period;
                mdl_interp = quot[7:0];
            end
            mdl_angle = mdl_abs_angle + cfg_pos_corr + mdl_interp;
        end
        r.angle   = mdl_angle;
        r.erps    = mdl_erps;
        r.current = mdl_current;
        r.mode    = mdl_mode;
        r.interp  = mdl_interp;
        return r;
    endfunction

    // ---------------- stimulus helpers ----------------

    function automatic logic [9:0] rand_sample();
        int pick;
        pick = $urandom_range(9);
        if (pick == 0)
            return 10'h3ff;
        if (pick == 1)
            return 10'h000;
        return 10'($urandom_range(1023));
    endfunction

    function automatic logic rand_busy();
        return ($urandom_range(3) == 0);
    endfunction

    // Offer one tick transaction and record its prediction once accepted
    task automatic send_tick(input logic [2:0] code, input logic [9:0] sample,
                             input logic busy);
        tick_result_t r;
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tdata  <= {2'b00, busy, sample, code};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        r = predict_tick(code, sample, busy);
        pending_results.push_back(r);
        mode_hits[r.mode]++;
        ticks_sent++;
    endtask

    // Stop offering, wait for every pending result, then let the block settle
    task automatic wait_drained();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // APB write followed by a read-back of the same register
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        logic [31:0] rd;
        logic [31:0] want;
        string       name;
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        case (idx)
            REG_POS_CORR: begin
                cfg_pos_corr = val[7:0];
                want = {24'd0, cfg_pos_corr};
                name = "position_correction";
            end
            REG_PHASE_DELTA: begin
                cfg_phase_delta = val[7:0];
                want = {24'd0, cfg_phase_delta};
                name = "phase_delta_angle";
            end
            REG_INTERP_THR: begin
                cfg_interp_thr = val[15:0];
                want = {16'd0, cfg_interp_thr};
                name = "interpolation_threshold";
            end
            REG_CNT_LIMIT: begin
                cfg_cnt_limit = val[15:0];
                want = {16'd0, cfg_cnt_limit};
                name = "counter_limit";
            end
            default: begin
                cfg_tps = val[15:0];
                want = {16'd0, cfg_tps};
                name = "ticks_per_second";
            end
        endcase
        reg_writes++;
        @(negedge aclk);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        rd = prdata;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (rd !== want) begin
            $error("%s readback: expected %0d, actual %0d", name, want, rd);
            fail_count++;
        end
    endtask

    task automatic set_config(input logic [7:0] pos_corr, input logic [7:0] phase_delta,
                              input logic [15:0] interp_thr, input logic [15:0] cnt_limit,
                              input logic [15:0] tps);
        wait_drained();
        write_reg(REG_POS_CORR, {24'd0, pos_corr});
        write_reg(REG_PHASE_DELTA, {24'd0, phase_delta});
        write_reg(REG_INTERP_THR, {16'd0, interp_thr});
        write_reg(REG_CNT_LIMIT, {16'd0, cnt_limit});
        write_reg(REG_TPS, {16'd0, tps});
    endtask

    // Hall sequences: mostly clean rotation with random sector lengths,
    // occasional reversals, plus random codes (skips, 0 and 7) as noise
    task automatic drive_rotation(input int n_ticks, input int max_len, input int noise_pct);
        int         pos;
        int         dir;
        int         hold;
        int         sent;
        logic [2:0] code;
        pos  = $urandom_range(5);
        dir  = 1;
        sent = 0;
        while (sent < n_ticks) begin
            if ($urandom_range(99) < noise_pct) begin
                code = 3'($urandom_range(7));
            end else begin
                if ($urandom_range(99) < 4)
                    dir = -dir;
                pos  = (pos + dir + 6) % 6;
                code = ROT_ORDER[pos*3 +: 3];
            end
            hold = ($urandom_range(19) == 0) ? $urandom_range(4 * max_len, max_len)
                                             : $urandom_range(max_len, 1);
            repeat (hold) begin
                if (sent < n_ticks) begin
                    send_tick(code, rand_sample(), rand_busy());
                    sent++;
                end
            end
        end
    endtask

    // ---------------- tests ----------------

    // Every hall code, sample and busy extremes, repeated reference code
    task automatic test_directed_codes();
        send_tick(HALL_ALL_LOW, 10'h000, 1'b0);
        send_tick(HALL_ALL_HIGH, 10'h3ff, 1'b1);
        send_tick(HALL_SEC0, 10'h3ff, 1'b0);
        send_tick(HALL_SEC1, 10'h000, 1'b1);
        send_tick(HALL_SEC2, 10'h155, 1'b0);
        send_tick(HALL_REF, 10'h3ff, 1'b0);
        send_tick(HALL_REF, 10'h3ff, 1'b0);
        send_tick(HALL_SEC4, 10'h2aa, 1'b0);
        send_tick(HALL_SEC5, 10'h3ff, 1'b1);
        send_tick(HALL_REF, 10'h3ff, 1'b1);
        send_tick(HALL_ALL_LOW, 10'h000, 1'b0);
        send_tick(HALL_REF, 10'h3ff, 1'b0);
    endtask

    // Zero counter limit, zero ticks per second, zero period while interpolating
    task automatic test_special_cases();
        set_config(8'hff, 8'hff, INTERP_THR_RST, 16'd0, TPS_RST);
        send_tick(HALL_REF, rand_sample(), 1'b0);
        send_tick(HALL_REF, rand_sample(), 1'b0);
        send_tick(HALL_SEC0, rand_sample(), 1'b0);
        set_config(8'h00, 8'h00, INTERP_THR_RST, CNT_LIMIT_RST, 16'd0);
        send_tick(HALL_REF, rand_sample(), 1'b0);
        send_tick(HALL_SEC4, rand_sample(), 1'b0);
        send_tick(HALL_REF, rand_sample(), 1'b0);
        send_tick(HALL_SEC0, rand_sample(), 1'b0);
        set_config(8'h00, 8'h00, 16'hffff, 16'd2, TPS_RST);
        repeat (6) send_tick(HALL_REF, rand_sample(), rand_busy());
    endtask

    // Random rotation over several register settings and idle profiles
    task automatic test_random_rotation();
        for (int p = 0; p < PHASES; p++) begin
            case (p / 3)
                0:       begin send_idle_pct = 12; recv_idle_pct = 75; end
                1:       begin send_idle_pct = 75; recv_idle_pct = 12; end
                default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
            endcase
            case (p)
                0: set_config(8'($urandom_range(255)), 8'($urandom_range(255)),
                              INTERP_THR_RST, 16'd300, TPS_RST);
                1: set_config(8'hff, 8'hff, 16'd0, 16'd65534, 16'hffff);
                2: set_config(8'h00, 8'h00, 16'hffff, 16'd40, 16'd1);
                4: set_config(8'($urandom_range(255)), 8'($urandom_range(255)),
                              16'd60, 16'd1, 16'd0);
                6: set_config(8'($urandom_range(255)), 8'($urandom_range(255)),
                              INTERP_THR_RST, CNT_LIMIT_RST, TPS_RST);
                7: set_config(8'($urandom_range(255)), 8'($urandom_range(255)),
                              16'($urandom_range(65535)), 16'($urandom_range(65534, 1)),
                              16'($urandom_range(65535)));
                default: set_config(8'($urandom_range(255)), 8'($urandom_range(255)),
                                    16'($urandom_range(200, 20)), 16'($urandom_range(400, 30)),
                                    16'($urandom_range(65535)));
            endcase
            drive_rotation(PHASE_TICKS, $urandom_range(16, 3), (p == 5) ? 25 : 8);
        end
    endtask

    // Receiver holds off for a long stretch while ticks keep coming
    task automatic test_output_backpressure();
        wait_drained();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_left     = HOLD_CYCLES;
        drive_rotation(30, 4, 0);
        wait_drained();
    endtask

    // Sender pauses until every result is back, then resumes
    task automatic test_sender_pause();
        send_idle_pct = 12;
        recv_idle_pct = 12;
        drive_rotation(20, 6, 5);
        wait_drained();
        drive_rotation(20, 6, 5);
    endtask

    // ---------------- receiver and checker ----------------

    initial begin : receiver
        forever begin
            @(negedge aclk);
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endfunction

    // Compare each result transaction with the oldest prediction
    always @(posedge aclk) begin
        tick_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $error("result transaction with no tick pending: tdata %h", m_tdata);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("rotor_angle", {8'd0, want.angle}, {8'd0, m_tdata[7:0]});
                check_field("speed_erps", want.erps, m_tdata[23:8]);
                check_field("current_avg", {6'd0, want.current}, {6'd0, m_tdata[33:24]});
                check_field("motor_mode", {14'd0, want.mode}, {14'd0, m_tdata[35:34]});
                check_field("interp_angle", {8'd0, want.interp}, {8'd0, m_tdata[43:36]});
            end
        end
    end

    // Watchdog: too long without any stream transaction ends the run
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("timeout: %0d cycles with no transaction", QUIET_LIMIT);
        $display("** hall_rotor_angle_interpolator: FAILED **");
        $finish;
    end

    // ---------------- sequence ----------------

    initial begin : main
        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn <= 1'b1;
        test_directed_codes();
        test_special_cases();
        test_random_rotation();
        test_output_backpressure();
        test_sender_pause();
        wait_drained();
        $display("Covered %0d PWM ticks, %0d register writes, a long output stall and a drained pause.",
                 ticks_sent, reg_writes);
        $display("Predicted modes: coast %0d, very slow %0d, interpolated %0d.",
                 mode_hits[MODE_COAST], mode_hits[MODE_SLOW], mode_hits[MODE_RUN]);
        if (fail_count == 0)
            $display("** hall_rotor_angle_interpolator: PASSED **");
        else
            $display("** hall_rotor_angle_interpolator: FAILED **");
        $finish;
    end

endmodule
